FILE: design/rgbcf_pkg.sv
// Shared types, constants and a helper function of the RGB 3x3 convolution filter.
`default_nettype none
package rgbcf_pkg;
   localparam int MaxLineWidth = 1024;
   localparam int ColBits      = $clog2(MaxLineWidth);
   localparam int RowBits      = 12;
   localparam int PixBits      = 24;
   localparam int CoefBits     = 16;
   localparam int ProdBits     = 26;
   localparam int SumBits      = 30;
   localparam int DivBits      = 10;
   localparam int WidthBits    = 11;
   localparam int HeightBits   = 13;
   localparam int QuoBits      = SumBits + 1;
   localparam logic [WidthBits-1:0]  MaxWidth  = WidthBits'(MaxLineWidth);
   localparam logic [HeightBits-1:0] MaxHeight = HeightBits'(4096);

   localparam logic [2:0] REG_KERNEL_TOP    = 3'd0;
   localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd1;
   localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd2;
   localparam logic [2:0] REG_SUM_DIVISOR   = 3'd3;
   localparam logic [2:0] REG_FRAME_WIDTH   = 3'd4;
   localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd5;

   typedef logic [PixBits-1:0] pixel_type;
   typedef logic signed [SumBits-1:0] sum_type;

   typedef struct packed {
      logic                 last;
      logic [DivBits-1:0]   divisor;
   } tag_type;

   function automatic logic [7:0] clamp_u8(input logic signed [QuoBits-1:0] v);
      logic [7:0] r;
      if (v < 0) r = 8'd0;
      else if (v > QuoBits'(255)) r = 8'd255;
      else r = v[7:0];
      return r;
   endfunction
endpackage
`default_nettype wire

FILE: design/rgbcf_if.sv
// Valid/ready channel interfaces for pixels, results and register writes.
`default_nettype none
interface rgbcf_pix_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   modport source (output valid, red_in, green_in, blue_in, input ready);
   modport sink (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface rgbcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       last_of_frame;
   modport source (output valid, red_out, green_out, blue_out, last_of_frame, input ready);
   modport sink (input valid, red_out, green_out, blue_out, last_of_frame, output ready);
endinterface

interface rgbcf_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [47:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/rgbcf_ram.sv
// Generic single-port-write, single-read RAM with a registered read port.
`default_nettype none
module rgbcf_ram #(
   parameter int Width = 24,
   parameter int Depth = 1024
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(Depth)-1:0]  wr_addr,
   input  wire [Width-1:0]          wr_data,
   input  wire                      rd_en,
   input  wire [$clog2(Depth)-1:0]  rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: design/rgbcf_div.sv
// Sequential signed divider: restoring division, one quotient bit per cycle.
`default_nettype none
module rgbcf_div
   import rgbcf_pkg::*;
(
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire signed [SumBits-1:0]    dividend,
   input  wire [DivBits-1:0]           divisor,
   output logic                        busy,
   output logic                        done,
   output logic signed [QuoBits-1:0]   quotient
);
   localparam int CntBits = $clog2(SumBits + 1);

   logic [SumBits-1:0]  mag_ff, mag_in;
   logic [DivBits:0]    rem_ff, rem_in;
   logic [DivBits-1:0]  dsr_ff, dsr_in;
   logic                neg_ff, neg_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DivBits:0]    trial;

   always_comb begin
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DivBits-1:0], mag_ff[SumBits-1]};
      if (start) begin
         mag_in  = dividend[SumBits-1] ? SumBits'(-dividend) : dividend;
         neg_in  = dividend[SumBits-1];
         dsr_in  = divisor;
         rem_in  = '0;
         cnt_in  = CntBits'(SumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            mag_in = {mag_ff[SumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            mag_in = {mag_ff[SumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
endmodule
`default_nettype wire

FILE: design/rgb_3x3_convolution_filter_top.sv
// Top level of the RGB 3x3 convolution filter with line stores in RAM.
//
// Pixels enter on req_ in raster order; one result per interior pixel leaves
// on rsp_, for the window centered one row up and one column left of the
// pixel just taken. The user must write registers on csr_ only while the
// block is idle; the block itself does not enforce this. An item is taken
// in the read cycle of the two line-store RAMs, then the window shifts and
// three channels are weighted with 9 multipliers each, summed in a
// registered adder stage. With a divisor above 1 the sums then pass through
// the bit-serial divider that each of the three channels runs in turn. One
// item is in work at a time, so a pixel is not taken before the last one
// has reached the output register.
// Edge rows and columns give no result.
// Reset clears counters and restores the identity kernel, divisor 1 and a
// 1024x1024 frame. While rsp_ is stalled the result waits in its output
// register; the next pixel is still taken and its result holds in the
// output stage until the register frees, and no further pixel is taken.
`default_nettype none
module rgb_3x3_convolution_filter_top
   import rgbcf_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   rgbcf_pix_if.sink    req,
   rgbcf_rsp_if.source  rsp,
   rgbcf_csr_if.sink    csr
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_MULT = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_WAIT = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [47:0] krow_ff [3];
   logic [DivBits-1:0]    div_ff;
   logic [WidthBits-1:0]  wid_ff;
   logic [HeightBits-1:0] hgt_ff;
   logic [ColBits-1:0]    col_ff, col_in;
   logic [RowBits-1:0]    row_ff, row_in;
   pixel_type             pix_ff;
   pixel_type             win_ff [3][3];
   logic                  emit_ff, emit_in;
   tag_type               tag_ff;
   logic signed [ProdBits-1:0] prod_ff [3][9];
   sum_type               sum_ff [3];
   logic signed [QuoBits-1:0] quo_ff [3];
   logic [1:0]            ch_ff, ch_in;
   logic [7:0]            res_ff [3];
   logic                  res_last_ff;
   logic                  rsp_valid_ff;
   pixel_type             up_rd, lo_rd;
   logic [WidthBits-1:0]  w_eff;
   logic [HeightBits-1:0] h_eff;
   logic                  col_wrap, row_wrap, is_last;
   logic                  div_start, div_busy, div_done;
   logic signed [QuoBits-1:0] div_q;
   logic                  req_fire;
   logic                  store_wr;
   logic                  out_load;

   assign w_eff = (wid_ff < WidthBits'(3)) ? WidthBits'(3) :
                  (wid_ff > MaxWidth) ? MaxWidth : wid_ff;
   assign h_eff = (hgt_ff < HeightBits'(3)) ? HeightBits'(3) :
                  (hgt_ff > MaxHeight) ? MaxHeight : hgt_ff;
   assign col_wrap = ({1'b0, col_ff} + 1'b1) >= w_eff;
   assign row_wrap = ({1'b0, row_ff} + 1'b1) >= h_eff;
   assign is_last  = ({1'b0, row_ff} == h_eff - 1'b1) &&
                     ({1'b0, col_ff} == w_eff - 1'b1);

   assign req.ready = (state_ff == ST_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign store_wr  = (state_ff == ST_READ);
   // The output stage loads only once the previous result has left.
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp.ready);

   rgbcf_ram #(.Width(PixBits), .Depth(MaxLineWidth)) u_upper (
      .clock(clock), .wr_en(store_wr), .wr_addr(col_ff), .wr_data(lo_rd),
      .rd_en(req_fire), .rd_addr(col_ff), .rd_data(up_rd));
   rgbcf_ram #(.Width(PixBits), .Depth(MaxLineWidth)) u_lower (
      .clock(clock), .wr_en(store_wr), .wr_addr(col_ff), .wr_data(pix_ff),
      .rd_en(req_fire), .rd_addr(col_ff), .rd_data(lo_rd));

   assign div_start = (state_ff == ST_DIV)
                      || (state_ff == ST_WAIT) && div_done && (ch_ff != 2'd2);

   rgbcf_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .dividend(sum_ff[(state_ff == ST_DIV) ? 2'd0 : ch_ff + 2'd1]),
      .divisor(tag_ff.divisor), .busy(div_busy), .done(div_done), .quotient(div_q));

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      emit_in  = emit_ff;
      ch_in    = ch_ff;
      case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_READ;
         ST_READ: begin
            emit_in = (row_ff >= RowBits'(2)) && (col_ff >= ColBits'(2));
            if (col_wrap) begin
               col_in = '0;
               row_in = row_wrap ? '0 : row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
            state_in = ST_MULT;
         end
         ST_MULT: state_in = emit_ff ? ST_SUM : ST_IDLE;
         ST_SUM: begin
            ch_in    = 2'd0;
            state_in = (tag_ff.divisor > DivBits'(1)) ? ST_DIV : ST_OUT;
         end
         ST_DIV: state_in = ST_WAIT;
         ST_WAIT: if (div_done) begin
            if (ch_ff == 2'd2) state_in = ST_OUT;
            else ch_in = ch_ff + 2'd1;
         end
         ST_OUT: if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         emit_ff      <= 1'b0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         krow_ff[0]   <= 48'd0;
         krow_ff[1]   <= 48'd65536;
         krow_ff[2]   <= 48'd0;
         div_ff       <= DivBits'(1);
         wid_ff       <= WidthBits'(1024);
         hgt_ff       <= HeightBits'(1024);
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         emit_ff  <= emit_in;
         ch_ff    <= ch_in;
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         if (csr.valid) begin
            case (csr.index)
               REG_KERNEL_TOP:    krow_ff[0] <= csr.data;
               REG_KERNEL_MIDDLE: krow_ff[1] <= csr.data;
               REG_KERNEL_BOTTOM: krow_ff[2] <= csr.data;
               REG_SUM_DIVISOR:   div_ff <= csr.data[DivBits-1:0];
               REG_FRAME_WIDTH:   wid_ff <= csr.data[WidthBits-1:0];
               REG_FRAME_HEIGHT:  hgt_ff <= csr.data[HeightBits-1:0];
               default: ;
            endcase
         end
      end
   end

   // Datapath registers; none of them needs a reset.
   always_ff @(posedge clock) begin
      if (req_fire) pix_ff <= {req.blue_in, req.green_in, req.red_in};
      if (state_ff == ST_READ) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= up_rd;
         win_ff[1][2] <= lo_rd;
         win_ff[2][2] <= pix_ff;
         tag_ff.last    <= is_last;
         tag_ff.divisor <= div_ff;
      end
      if (state_ff == ST_MULT) begin
         for (int c = 0; c < 3; c++)
            for (int k = 0; k < 9; k++)
               prod_ff[c][k] <= ProdBits'($signed({1'b0, win_ff[k/3][k%3][8*c +: 8]}) *
                                $signed(krow_ff[k/3][16*(k%3) +: 16]));
      end
      if (state_ff == ST_SUM) begin
         for (int c = 0; c < 3; c++) begin
            sum_ff[c] <= SumBits'(prod_ff[c][0]) + SumBits'(prod_ff[c][1])
                       + SumBits'(prod_ff[c][2]) + SumBits'(prod_ff[c][3])
                       + SumBits'(prod_ff[c][4]) + SumBits'(prod_ff[c][5])
                       + SumBits'(prod_ff[c][6]) + SumBits'(prod_ff[c][7])
                       + SumBits'(prod_ff[c][8]);
         end
      end
      if (state_ff == ST_WAIT && div_done) quo_ff[ch_ff] <= div_q;
      if (out_load) begin
         for (int c = 0; c < 3; c++)
            res_ff[c] <= clamp_u8((tag_ff.divisor > DivBits'(1)) ? quo_ff[c]
                                  : QuoBits'(sum_ff[c]));
         res_last_ff <= tag_ff.last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.red_out       = res_ff[0];
   assign rsp.green_out     = res_ff[1];
   assign rsp.blue_out      = res_ff[2];
   assign rsp.last_of_frame = res_last_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("pixel taken while busy");
   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ({1'b0, col_ff} < w_eff || !$stable(wid_ff)))
      else $error("column out of range");
   a_out_loads_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |=> rsp.valid) else $error("result not presented");
   a_div_idle_outside: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == ST_WAIT)) else $error("divider busy out of order");
`endif
endmodule
`default_nettype wire
